[sv/crrl_pkg.sv]
// Shared types, constants and helpers of the congestion reaction rate limiter.
// Used by crrl_ctrl, crrl_datapath and the top level; depends on nothing.
package crrl_pkg;

  // Fixed widths of the rate and the registers.
  localparam int unsigned RateW = 32;
  localparam int unsigned StgW  = 8;

  // Credit refill scale (Q8) and timer enable.
  localparam logic [9:0] EXPIRE_SCALE_Q8 = 10'd256;
  localparam logic       USE_TIMER       = 1'b1;

  localparam logic [16:0] Q16_ONE = 17'h10000;

  // Reset values of the configuration registers.
  localparam logic [31:0] MAX_RATE_RST  = 32'd10000000;
  localparam logic [31:0] MIN_RATE_RST  = 32'd10000;
  localparam logic [23:0] BYTE_LIM_RST  = 24'd150000;
  localparam logic [15:0] GAIN_RST      = 16'd512;
  localparam logic [16:0] MIN_FACT_RST  = 17'd32768;
  localparam logic [23:0] ACT_INC_RST   = 24'd5000;
  localparam logic [23:0] HYP_INC_RST   = 24'd50000;
  localparam logic [7:0]  REC_THR_RST   = 8'd5;

  typedef enum logic [1:0] {
    OP_FEEDBACK = 2'd0,
    OP_XMIT     = 2'd1,
    OP_TIMER    = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_MAX_RATE = 3'd0,
    CFG_MIN_RATE = 3'd1,
    CFG_BYTE_LIM = 3'd2,
    CFG_GAIN     = 3'd3,
    CFG_MIN_FACT = 3'd4,
    CFG_ACT_INC  = 3'd5,
    CFG_HYP_INC  = 3'd6,
    CFG_REC_THR  = 3'd7
  } cfg_idx_e;

  // Datapath steps sequenced by the controller.
  typedef enum logic [2:0] {
    STEP_NONE  = 3'd0,
    STEP_EVAL  = 3'd1,
    STEP_MID   = 3'd2,
    STEP_APPLY = 3'd3,
    STEP_FINAL = 3'd4
  } step_e;

  typedef struct packed {
    step_e step;
    logic  capture;
    logic  publish;
  } dp_cmd_t;

  function automatic logic [StgW-1:0] sat_inc8(input logic [StgW-1:0] v);
    return (v == '1) ? v : v + 8'd1;
  endfunction

endpackage

[sv/crrl_ctrl.sv]
// Controller of the congestion reaction rate limiter: sequences datapath steps
// and owns both channel handshakes. Depends on crrl_pkg.
module crrl_ctrl
  import crrl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  logic    proceed_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MID,
    ST_APPLY,
    ST_FINAL,
    ST_PUB
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;
  logic   accept_in;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == ST_IDLE) || ((state_q == ST_PUB) && slot_free));
  assign accept_in   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.capture = accept_in;
    cmd_o.publish = (state_q == ST_PUB) && slot_free;
    case (state_q)
      ST_EVAL:  cmd_o.step = STEP_EVAL;
      ST_MID:   cmd_o.step = STEP_MID;
      ST_APPLY: cmd_o.step = STEP_APPLY;
      ST_FINAL: cmd_o.step = STEP_FINAL;
      default:  cmd_o.step = STEP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // drop the result once taken; a new publish overrides
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept_in) state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          state_q <= proceed_i ? ST_MID : ST_PUB;
        end
        ST_MID:   state_q <= ST_APPLY;
        ST_APPLY: state_q <= ST_FINAL;
        ST_FINAL: state_q <= ST_PUB;
        ST_PUB: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            state_q     <= accept_in ? ST_EVAL : ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_short_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) && !proceed_i |=> (state_q == ST_PUB))
    else $error("event without recovery work did not go to publish");

  a_publish_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |=> out_valid_q)
    else $error("published result not presented");

  a_final_to_pub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINAL) |=> (state_q == ST_PUB))
    else $error("final step not followed by publish");

  a_held_result_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUB) && out_valid_q && out_stall_i |=> (state_q == ST_PUB) && out_valid_q)
    else $error("pending result overwritten");

  a_no_capture_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step != STEP_NONE) |-> !cmd_o.capture)
    else $error("input transfer while an event is in progress");

endmodule

[sv/crrl_datapath.sv]
// Datapath of the congestion reaction rate limiter: configuration registers,
// limiter state, decrease and recovery arithmetic, result register. Uses crrl_pkg.
module crrl_datapath
  import crrl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i,
  input  logic [1:0]       op_i,
  input  logic [5:0]       fb_i,
  input  logic signed [15:0] qoff_i,
  input  logic [13:0]      frame_bytes_i,
  input  dp_cmd_t          cmd_i,
  output logic             proceed_o,
  output logic [31:0]      current_rate_o,
  output logic [31:0]      target_rate_o,
  output logic             limiter_active_o,
  output logic             timer_start_o,
  output logic             timer_half_o,
  output logic             timer_stop_o
);

  // event
  op_e          op_q;
  logic [5:0]   fb_q;
  logic         qneg_q;
  logic [13:0]  fbytes_q;

  // configuration
  logic [31:0]  max_rate_q, min_rate_q;
  logic [23:0]  byte_lim_q, act_inc_q, hyp_inc_q;
  logic [15:0]  gain_q;
  logic [16:0]  min_fact_q;
  logic [7:0]   rec_thr_q;

  // limiter state
  logic             active_q, timer_run_q;
  logic [31:0]      rate_now_q, rate_goal_q, credit_q;
  logic [StgW-1:0]  byte_stg_q, timer_stg_q;

  // work registers
  logic [21:0]  cut_q;
  logic [16:0]  factor_q;
  logic [31:0]  prod_q, step_q;
  logic         div_q;
  logic         t_start_q, t_half_q, t_stop_q;

  // result register
  logic [31:0]  res_now_q, res_goal_q;
  logic         res_act_q, res_start_q, res_half_q, res_stop_q;

  logic [21:0]  cut_full;
  logic [21:0]  one_minus_cut;
  logic [16:0]  factor_raw, floor_f, factor_d;
  logic [33:0]  scaled;
  logic [31:0]  refill;
  logic [StgW-1:0] lo_stg, lo_minus;
  logic         any_over, both_over;
  logic [31:0]  hyp_step, step_d;
  logic [35:0]  ten_now;
  logic         div_d;
  logic [32:0]  goal_sum, avg_sum;
  logic [31:0]  goal_sat, avg_cap;
  logic [48:0]  prod_full;
  logic [31:0]  credit_left;
  logic         xmit_exhaust;

  // decrease factor: 1 - gain*fb, floored
  assign cut_full      = 22'(gain_q) * 22'(fb_q);
  assign one_minus_cut = 22'(22'h10000 - cut_q);
  assign factor_raw    = (cut_q >= 22'h10000) ? 17'd0 : one_minus_cut[16:0];
  assign floor_f       = (min_fact_q > Q16_ONE) ? Q16_ONE : min_fact_q;
  assign factor_d      = (factor_raw < floor_f) ? floor_f : factor_raw;
  assign prod_full     = 49'(rate_now_q) * 49'(factor_q);

  // byte credit
  assign credit_left  = credit_q - {18'd0, fbytes_q};
  assign xmit_exhaust = {18'd0, fbytes_q} > credit_q;
  assign scaled       = 34'(byte_lim_q) * 34'(EXPIRE_SCALE_Q8);
  assign refill       = (byte_stg_q < rec_thr_q) ? 32'(scaled >> 8) : 32'(scaled >> 9);

  // recovery target step
  assign lo_stg    = (byte_stg_q < timer_stg_q) ? byte_stg_q : timer_stg_q;
  assign lo_minus  = lo_stg - rec_thr_q;
  assign any_over  = (byte_stg_q > rec_thr_q) || (timer_stg_q > rec_thr_q);
  assign both_over = (byte_stg_q > rec_thr_q) && (timer_stg_q > rec_thr_q);
  assign hyp_step  = {8'd0, hyp_inc_q} * {24'd0, lo_minus};
  assign step_d    = both_over ? hyp_step : (any_over ? {8'd0, act_inc_q} : 32'd0);
  assign ten_now   = {1'b0, rate_now_q, 3'b000} + {3'b000, rate_now_q, 1'b0};
  assign div_d     = ((byte_stg_q == 8'd1) || (timer_stg_q == 8'd1)) &&
                     ({4'd0, rate_goal_q} > ten_now);

  assign goal_sum = {1'b0, rate_goal_q} + {1'b0, step_q};
  assign goal_sat = goal_sum[32] ? '1 : goal_sum[31:0];
  assign avg_sum  = {1'b0, rate_goal_q} + {1'b0, rate_now_q} + 33'd1;
  assign avg_cap  = (avg_sum[32:1] > max_rate_q) ? max_rate_q : avg_sum[32:1];

  always_comb begin
    case (op_q)
      OP_FEEDBACK: proceed_o = (fb_q != 6'd0) && (active_q || qneg_q);
      OP_XMIT:     proceed_o = (rate_now_q != max_rate_q) && xmit_exhaust;
      OP_TIMER:    proceed_o = active_q;
      default:     proceed_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= OP_NONE;
      fb_q        <= '0;
      qneg_q      <= 1'b0;
      fbytes_q    <= '0;
      max_rate_q  <= MAX_RATE_RST;
      min_rate_q  <= MIN_RATE_RST;
      byte_lim_q  <= BYTE_LIM_RST;
      gain_q      <= GAIN_RST;
      min_fact_q  <= MIN_FACT_RST;
      act_inc_q   <= ACT_INC_RST;
      hyp_inc_q   <= HYP_INC_RST;
      rec_thr_q   <= REC_THR_RST;
      active_q    <= 1'b0;
      timer_run_q <= 1'b0;
      rate_now_q  <= MAX_RATE_RST;
      rate_goal_q <= MAX_RATE_RST;
      credit_q    <= {8'd0, BYTE_LIM_RST};
      byte_stg_q  <= '0;
      timer_stg_q <= '0;
      cut_q       <= '0;
      factor_q    <= '0;
      prod_q      <= '0;
      step_q      <= '0;
      div_q       <= 1'b0;
      t_start_q   <= 1'b0;
      t_half_q    <= 1'b0;
      t_stop_q    <= 1'b0;
      res_now_q   <= '0;
      res_goal_q  <= '0;
      res_act_q   <= 1'b0;
      res_start_q <= 1'b0;
      res_half_q  <= 1'b0;
      res_stop_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MAX_RATE: max_rate_q <= cfg_data_i;
          CFG_MIN_RATE: min_rate_q <= cfg_data_i;
          CFG_BYTE_LIM: byte_lim_q <= cfg_data_i[23:0];
          CFG_GAIN:     gain_q     <= cfg_data_i[15:0];
          CFG_MIN_FACT: min_fact_q <= cfg_data_i[16:0];
          CFG_ACT_INC:  act_inc_q  <= cfg_data_i[23:0];
          CFG_HYP_INC:  hyp_inc_q  <= cfg_data_i[23:0];
          CFG_REC_THR:  rec_thr_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end

      if (cmd_i.publish) begin
        res_now_q   <= rate_now_q;
        res_goal_q  <= rate_goal_q;
        res_act_q   <= active_q;
        res_start_q <= t_start_q;
        res_half_q  <= t_half_q;
        res_stop_q  <= t_stop_q;
      end

      if (cmd_i.capture) begin
        op_q      <= op_e'(op_i);
        fb_q      <= fb_i;
        qneg_q    <= qoff_i[15];
        fbytes_q  <= frame_bytes_i;
        t_start_q <= 1'b0;
        t_half_q  <= 1'b0;
        t_stop_q  <= 1'b0;
      end

      case (cmd_i.step)
        STEP_EVAL: begin
          cut_q <= cut_full;
          case (op_q)
            OP_FEEDBACK: begin
              if (!active_q && (fb_q != 6'd0) && qneg_q) begin
                active_q    <= 1'b1;
                rate_now_q  <= max_rate_q;
                rate_goal_q <= max_rate_q;
                byte_stg_q  <= '0;
              end
            end
            OP_XMIT: begin
              if (rate_now_q == max_rate_q) begin
                // back at line rate: release the limiter
                active_q    <= 1'b0;
                rate_goal_q <= max_rate_q;
                credit_q    <= {8'd0, byte_lim_q};
                byte_stg_q  <= '0;
                t_stop_q    <= timer_run_q;
                timer_run_q <= 1'b0;
              end else if (xmit_exhaust) begin
                byte_stg_q <= sat_inc8(byte_stg_q);
              end else begin
                credit_q <= credit_left;
              end
            end
            OP_TIMER: begin
              if (active_q) begin
                timer_stg_q <= sat_inc8(timer_stg_q);
              end else begin
                timer_run_q <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        STEP_MID: begin
          step_q <= step_d;
          div_q  <= div_d;
          case (op_q)
            OP_FEEDBACK: begin
              factor_q <= factor_d;
              if (byte_stg_q != '0) begin
                rate_goal_q <= rate_now_q;
                credit_q    <= {8'd0, byte_lim_q};
              end
              byte_stg_q  <= '0;
              timer_stg_q <= '0;
            end
            OP_XMIT: credit_q <= refill;
            default: ;
          endcase
        end
        STEP_APPLY: begin
          if (op_q == OP_FEEDBACK) begin
            prod_q <= prod_full[47:16];
          end else begin
            rate_goal_q <= div_q ? (rate_goal_q >> 3) : goal_sat;
          end
        end
        STEP_FINAL: begin
          if (op_q == OP_FEEDBACK) begin
            rate_now_q <= (prod_q < min_rate_q) ? min_rate_q : prod_q;
            if (USE_TIMER) begin
              t_start_q   <= 1'b1;
              timer_run_q <= 1'b1;
            end
          end else begin
            rate_now_q <= avg_cap;
            if (USE_TIMER && (op_q == OP_TIMER)) begin
              t_start_q   <= 1'b1;
              t_half_q    <= (timer_stg_q >= rec_thr_q);
              timer_run_q <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign current_rate_o   = res_now_q;
  assign target_rate_o    = res_goal_q;
  assign limiter_active_o = res_act_q;
  assign timer_start_o    = res_start_q;
  assign timer_half_o     = res_half_q;
  assign timer_stop_o     = res_stop_q;

endmodule

[sv/congestion_reaction_rate_limiter_unit.sv]
// Top level of the congestion reaction rate limiter.
// Instantiates crrl_ctrl and crrl_datapath; uses crrl_pkg.

// Reaction-point rate limiter. Each input transfer is one event (feedback
// frame, transmitted frame, recovery timer expiry, op 3 ignored) and yields
// exactly one result transfer carrying the current and target rate in kbit/s,
// the engaged flag and the timer start/half/stop requests. A feedback frame
// that cuts the rate, and a transmit or timer event that runs a recovery step,
// pass through evaluate, factor/step, multiply or new target, floor or average
// and publish; all other events go from evaluate straight to publish. The
// multiply step uses the one 32x17 rate multiplier. The next input transfer
// can be taken in the publish cycle if no earlier result is left waiting.
// A finished result sits in an output register, so one more event is taken
// and worked while it waits; a second finished result holds until the first
// is taken. Configuration writes are single-cycle, index 0..7, and must
// happen only while no event is in progress.
module congestion_reaction_rate_limiter_unit
  import crrl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  // event channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [5:0]         fb_i,
  input  logic signed [15:0] qoff_i,
  input  logic [13:0]        frame_bytes_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        current_rate_o,
  output logic [31:0]        target_rate_o,
  output logic               limiter_active_o,
  output logic               timer_start_o,
  output logic               timer_half_o,
  output logic               timer_stop_o
);

  dp_cmd_t dp_cmd;
  logic    dp_proceed;

  // Sequencer: owns both handshakes and advances the datapath step by step.
  crrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .proceed_i   (dp_proceed),
    .cmd_o       (dp_cmd)
  );

  // Arithmetic, limiter state, registers and the result register.
  crrl_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .op_i             (op_i),
    .fb_i             (fb_i),
    .qoff_i           (qoff_i),
    .frame_bytes_i    (frame_bytes_i),
    .cmd_i            (dp_cmd),
    .proceed_o        (dp_proceed),
    .current_rate_o   (current_rate_o),
    .target_rate_o    (target_rate_o),
    .limiter_active_o (limiter_active_o),
    .timer_start_o    (timer_start_o),
    .timer_half_o     (timer_half_o),
    .timer_stop_o     (timer_stop_o)
  );

endmodule
